[rtl/box_blur_3x3_stream_top_macros.svh]
// ----------------------------------------------------------------------------
// Box blur 3x3 stream: assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_STREAM_TOP_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_TOP_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define BB_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define BB_ASSERT(lbl, prop, msg) \
  `BB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/bblur_pkg.sv]
// ----------------------------------------------------------------------------
// Box blur 3x3 stream: package
// Widths, register codes and shared helpers of the box blur block.
// ----------------------------------------------------------------------------
`default_nettype none

package bblur_pkg;

  localparam int unsigned CfgW         = 11;
  localparam int unsigned ChanW        = 8;
  localparam int unsigned PixW         = 24;
  localparam int unsigned SumW         = 12;
  localparam int unsigned WordW        = 32;
  localparam int unsigned OutColW      = 10;
  localparam int unsigned OutRowW      = 10;
  localparam int unsigned InDataW      = 24;
  localparam int unsigned OutDataW     = 56;
  localparam int unsigned OutPadW      = OutDataW - WordW - OutColW - OutRowW;
  localparam int unsigned ApbAddrW     = 3;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;

  localparam logic [CfgW-1:0]  CfgSizeReset = 11'd1024;
  localparam logic [ChanW-1:0] AlphaOpaque  = 8'hFF;
  localparam logic [12:0]      Recip9       = 13'd7282;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // Truncating division by nine for sums up to 9 * 255.
  function automatic logic [ChanW-1:0] div9(input logic [SumW-1:0] s);
    logic [SumW+13-1:0] prod;
    prod = (SumW + 13)'(s) * (SumW + 13)'(Recip9);
    return prod[23:16];
  endfunction

endpackage

`default_nettype wire

[rtl/box_blur_3x3_stream_top.sv]
// ----------------------------------------------------------------------------
// Box blur 3x3 stream: top level
// Blurs a raster pixel stream over a 3x3 window using one line memory.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Content
//  s_axis    in         tvalid / tready          pixel or drain item
//  m_axis    out        tvalid / tready          blurred RGBA word and position
//  apb       in         psel / penable / pwrite  frame_width, frame_height
//
//  One item per clock is sustained when nothing stalls; a result passes the
//  stage 1, sum and output registers after its item is accepted.
//  The line memory is read at acceptance and written one stage later, and a
//  bypass register covers a read of the column written in the same cycle.
//  A stall on m_axis fills the stages one by one; s_axis_tready drops only
//  once all stages hold an item.
//  Reset clears counters and window and sets the configuration to 1024; the
//  line memory needs no clearing pass.
//
`default_nettype none

module box_blur_3x3_stream_top
  import bblur_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // red_in, green_in, blue_in
  input  logic                s_axis_tuser,   // op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // blurred_word, out_col, out_row, pad
  output logic                m_axis_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned ColExtW = (CW > OutColW) ? CW : OutColW;
  localparam int unsigned RowExtW = (RW > OutRowW) ? RW : OutRowW;

  typedef struct packed {
    logic [CW-1:0]   col;
    logic [PixW-1:0] pix;
    logic            top_en;
    logic            mid_en;
    logic            col0;
    logic            emit;
    logic [RW-1:0]   erow;
    logic [CW-1:0]   ecol;
    logic            done;
    logic            clr;
  } stage1_t;

  // Configuration
  logic [CfgW-1:0] frame_width_q, frame_height_q;
  logic [WW-1:0]   width_c;
  logic [HW-1:0]   height_c;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgSizeReset;
      frame_height_q <= CfgSizeReset;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[ApbAddrW-1]))
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CfgW-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[ApbAddrW-1]))
      REG_FRAME_WIDTH:  prdata = ApbDataW'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = ApbDataW'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (frame_width_q == '0) begin
      width_c = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      width_c = WW'(MAX_WIDTH);
    end else begin
      width_c = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_c = HW'(1);
    end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
      height_c = HW'(MAX_HEIGHT);
    end else begin
      height_c = HW'(frame_height_q);
    end
  end

  // Handshake between stages
  logic v1_q, v2_q, out_v_q;
  logic adv1, adv2, in_acc;

  assign adv2          = v2_q && (!out_v_q || m_axis_tready);
  assign adv1          = v1_q && (!v2_q || adv2);
  assign s_axis_tready = !v1_q || adv1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Position counters and per-item control at acceptance
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [RW-1:0] h_r;
  logic [WW-1:0] c_w, c_inc;
  logic [RW-1:0] row_adv;
  logic          wrap;
  stage1_t       s1_d, s1_q;

  always_comb begin
    h_r   = RW'(height_c);
    c_w   = WW'(col_q);
    c_inc = c_w + WW'(1);
    wrap  = c_inc >= width_c;

    s1_d        = '0;
    s1_d.col    = col_q;
    s1_d.top_en = row_q >= RW'(2);
    s1_d.mid_en = row_q >= RW'(1);
    s1_d.col0   = col_q == '0;
    if (op_e'(s_axis_tuser) == OP_PIXEL && row_q < h_r && c_w < width_c) begin
      s1_d.pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
    end
    if (s1_d.col0) begin
      s1_d.emit = (row_q >= RW'(2)) && ((row_q - RW'(2)) < h_r);
      s1_d.erow = row_q - RW'(2);
      s1_d.ecol = CW'(width_c - WW'(1));
    end else begin
      s1_d.emit = (row_q >= RW'(1)) && ((row_q - RW'(1)) < h_r)
                  && ((c_w - WW'(1)) < width_c);
      s1_d.erow = row_q - RW'(1);
      s1_d.ecol = col_q - CW'(1);
    end
    s1_d.done = s1_d.emit && (s1_d.erow == h_r - RW'(1))
                && (s1_d.ecol == CW'(width_c - WW'(1)));

    row_adv   = wrap ? row_q + RW'(1) : row_q;
    s1_d.clr  = s1_d.done || (row_adv >= h_r + RW'(1));
    if (s1_d.clr) begin
      col_d = '0;
      row_d = '0;
    end else begin
      col_d = wrap ? '0 : CW'(c_inc);
      row_d = row_adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_acc) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // Line memory: upper row in the high half, middle row in the low half
  logic [2*PixW-1:0] line_mem [MAX_WIDTH];
  logic [2*PixW-1:0] rd_q, wr_data, line_c;
  logic [2*PixW-1:0] byp_data_q;
  logic [CW-1:0]     byp_col_q;
  logic              byp_v_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem[col_q];
    end
    if (adv1) begin
      line_mem[s1_q.col] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_v_q <= 1'b0;
    end else if (adv1) begin
      byp_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      byp_col_q  <= s1_q.col;
      byp_data_q <= wr_data;
    end
  end

  // Window update and channel sums
  logic [PixW-1:0] win_q [9];
  logic [PixW-1:0] win_d [9];
  logic [PixW-1:0] shift_c [9];
  logic [PixW-1:0] new_col [3];
  logic [PixW-1:0] top_c, mid_c;
  logic [SumW-1:0] sum_r, sum_g, sum_b;

  always_comb begin
    line_c = (byp_v_q && byp_col_q == s1_q.col) ? byp_data_q : rd_q;
    top_c  = s1_q.top_en ? line_c[2*PixW-1:PixW] : '0;
    mid_c  = s1_q.mid_en ? line_c[PixW-1:0] : '0;
    wr_data = {mid_c, s1_q.pix};
    new_col[0] = top_c;
    new_col[1] = mid_c;
    new_col[2] = s1_q.pix;

    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < 3; i++) begin
      shift_c[i*3]   = win_q[i*3+1];
      shift_c[i*3+1] = win_q[i*3+2];
      shift_c[i*3+2] = s1_q.col0 ? '0 : new_col[i];
      for (int j = 0; j < 3; j++) begin
        sum_r = sum_r + SumW'(shift_c[i*3+j][23:16]);
        sum_g = sum_g + SumW'(shift_c[i*3+j][15:8]);
        sum_b = sum_b + SumW'(shift_c[i*3+j][7:0]);
        if (s1_q.clr) begin
          win_d[i*3+j] = '0;
        end else if (s1_q.col0) begin
          win_d[i*3+j] = (j == 2) ? new_col[i] : '0;
        end else begin
          win_d[i*3+j] = shift_c[i*3+j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (adv1) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  // Sum stage
  logic [SumW-1:0] s2_r_q, s2_g_q, s2_b_q;
  logic [CW-1:0]   s2_col_q;
  logic [RW-1:0]   s2_row_q;
  logic            s2_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv1) begin
      v2_q <= s1_q.emit;
    end else if (adv2) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_r_q    <= sum_r;
      s2_g_q    <= sum_g;
      s2_b_q    <= sum_b;
      s2_col_q  <= s1_q.ecol;
      s2_row_q  <= s1_q.erow;
      s2_done_q <= s1_q.done;
    end
  end

  // Output register
  logic [WordW-1:0]   out_word_q;
  logic [OutColW-1:0] out_col_q;
  logic [OutRowW-1:0] out_row_q;
  logic               out_last_q;
  logic [ColExtW-1:0] col_ext;
  logic [RowExtW-1:0] row_ext;

  assign col_ext = ColExtW'(s2_col_q);
  assign row_ext = RowExtW'(s2_row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv2) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      out_word_q <= {div9(s2_r_q), div9(s2_g_q), div9(s2_b_q), AlphaOpaque};
      out_col_q  <= col_ext[OutColW-1:0];
      out_row_q  <= row_ext[OutRowW-1:0];
      out_last_q <= s2_done_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {OutPadW'(0), out_row_q, out_col_q, out_word_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

[rtl/bblur_checker.sv]
// ----------------------------------------------------------------------------
// Box blur 3x3 stream: port checker
// Concurrent checks on the top level's ports, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_stream_top_macros.svh"

module bblur_checker
  import bblur_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ApbAddrW-1:0] paddr,
  input logic [ApbDataW-1:0] pwdata,
  input logic [ApbDataW-1:0] prdata,
  input logic                pready
);

  `BB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled item changed")
  `BB_ASSERT(a_alpha, m_axis_tvalid |-> m_axis_tdata[7:0] == AlphaOpaque, "alpha byte is not opaque")
  `BB_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")
  `BB_ASSERT(a_cfg_readback, psel && penable && pwrite && pready && paddr == '0 |=> paddr != '0 || prdata[CfgW-1:0] == $past(pwdata[CfgW-1:0]), "width register readback mismatch")

endmodule

bind box_blur_3x3_stream_top bblur_checker u_bblur_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

`default_nettype wire
